// File: sv/cds_pkg.sv
// cds_pkg: shared types and constants of the cyclic distance spectrum block
// used by cds_spectrum and cyclic_distance_spectrum; no dependencies
package cds_pkg;

  localparam int CDS_MAX_POSITIONS = 64;
  localparam int CDS_MAX_BLOCK     = 32768;

  // position port width and a width that holds any effective block size
  localparam int CDS_POS_W  = 15;
  localparam int CDS_P_W    = 17;
  localparam int CDS_BL_W   = 16;
  localparam int CDS_MULT_W = 3;
  localparam int CDS_HELD_W = 7;

  localparam logic [CDS_BL_W-1:0]   CDS_BL_RESET = 16'd4801;
  localparam logic [CDS_MULT_W-1:0] CDS_MULT_CAP = 3'd4;

  // spectrum entries carry a block tag so a new block needs no clearing pass
  localparam int CDS_EPOCH_W = 4;
  localparam logic [CDS_EPOCH_W-1:0] CDS_EPOCH_MAX   = {CDS_EPOCH_W{1'b1}};
  localparam logic [CDS_EPOCH_W-1:0] CDS_EPOCH_FIRST = 4'd1;
  localparam logic [CDS_EPOCH_W-1:0] CDS_EPOCH_NONE  = 4'd0;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef struct packed {
    logic [CDS_EPOCH_W-1:0] tag;
    logic [CDS_MULT_W-1:0]  cnt;
  } spec_entry_t;

endpackage

// File: sv/cds_spectrum.sv
// cds_spectrum: tagged spectrum table, one write port and one registered read port
// depends on cds_pkg for the entry type; an entry whose tag is stale reads as zero
module cds_spectrum
  import cds_pkg::*;
#(
  parameter int TABLE_DEPTH = CDS_MAX_BLOCK / 2,
  parameter int TA_W        = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk,
  input  logic [TA_W-1:0]        rd_addr,
  input  logic                   wr_en,
  input  logic [TA_W-1:0]        wr_addr,
  input  spec_entry_t            wr_entry,
  input  logic [CDS_EPOCH_W-1:0] cur_epoch,
  output logic [CDS_MULT_W-1:0]  rd_mult
);

  spec_entry_t spec_mem [TABLE_DEPTH];
  spec_entry_t rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      spec_mem[wr_addr] <= wr_entry;
    end
    rd_q_r <= spec_mem[rd_addr];
  end

  assign rd_mult = (rd_q_r.tag == cur_epoch) ? rd_q_r.cnt : '0;

endmodule

// File: sv/cyclic_distance_spectrum.sv
// cyclic_distance_spectrum: top level, position store, pair sequencer and spectrum table
// depends on cds_pkg and cds_spectrum
//
// Loads the ascending set-bit positions of one circulant block, one position per beat,
// and on the beat marked final walks every pair of held positions through one shared
// distance unit: a subtract, the cyclic fold min(d, p-d) and a read-modify-write of the
// saturating count in the spectrum table. Pairs are walked one after another, as the
// table has a single read-modify-write path. Table entries are tagged with a block
// number, so starting a block is free, except that after reset and on the first load of
// every fifteenth block the table is swept once, one entry per cycle, while input is
// stalled. Configuration writes are always taken. A result waits in an output register,
// and the next beat is taken meanwhile.
module cyclic_distance_spectrum
  import cds_pkg::*;
#(
  parameter int MAX_POSITIONS = CDS_MAX_POSITIONS,
  parameter int MAX_BLOCK     = CDS_MAX_BLOCK
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [CDS_POS_W-1:0]  in_position,
  input  logic                  in_final_position,
  input  logic [CDS_POS_W-1:0]  in_query_distance,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [CDS_MULT_W-1:0] out_multiplicity,
  output logic [CDS_HELD_W-1:0] out_positions_held,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CDS_BL_W-1:0]   cfg_block_length
);

  localparam int TABLE_DEPTH = MAX_BLOCK / 2;
  localparam int TA_W        = $clog2(TABLE_DEPTH);
  localparam int IDX_W       = $clog2(MAX_POSITIONS);
  localparam int CNT_W       = $clog2(MAX_POSITIONS + 1);
  localparam int D_W         = CDS_POS_W + 1;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CLEAR = 11'b000_0000_0010,
    S_CHECK = 11'b000_0000_0100,
    S_PA    = 11'b000_0000_1000,
    S_PB    = 11'b000_0001_0000,
    S_PC    = 11'b000_0010_0000,
    S_PD    = 11'b000_0100_0000,
    S_PE    = 11'b000_1000_0000,
    S_RQ    = 11'b001_0000_0000,
    S_RW    = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        i_r, i_nxt;
  logic [CNT_W-1:0]        j_r, j_nxt;
  logic [CDS_EPOCH_W-1:0]  epoch_r, epoch_nxt;
  logic                    block_done_r, block_done_nxt;
  logic [TA_W-1:0]         clr_addr_r, clr_addr_nxt;
  logic                    from_load_r, from_load_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [CDS_BL_W-1:0]     block_length_r;

  // beat payload and datapath registers
  logic                    final_r;
  logic [CDS_POS_W-1:0]    pos_r;
  logic [TA_W-1:0]         q_addr_r;
  logic                    q_ok_r;
  logic [CDS_P_W-1:0]      p_r;
  logic [CDS_POS_W-1:0]    last_pos_r;
  logic [CDS_POS_W-1:0]    pos_i_r;
  logic [CDS_POS_W-1:0]    d1_r;
  logic [D_W-1:0]          d_r;
  logic [TA_W-1:0]         tbl_addr_r;
  status_t                 status_r;
  logic [CDS_MULT_W-1:0]   mult_r;
  status_t                 out_status_r;
  logic [CDS_MULT_W-1:0]   out_mult_r;
  logic [CDS_HELD_W-1:0]   out_held_r;

  // position store
  logic [CDS_POS_W-1:0]    pos_mem [MAX_POSITIONS];
  logic [CDS_POS_W-1:0]    store_q;
  logic [IDX_W-1:0]        st_raddr;
  logic                    store_we;

  // table port
  logic                    tbl_we;
  logic [TA_W-1:0]         tbl_raddr;
  logic [TA_W-1:0]         tbl_waddr;
  spec_entry_t             tbl_wentry;
  logic [CDS_MULT_W-1:0]   tbl_mult;
  logic [CDS_MULT_W-1:0]   tbl_inc;

  logic                    in_accept;
  logic                    out_load;
  logic [CDS_P_W-1:0]      eff_p;
  logic                    q_ok;
  logic [CNT_W-1:0]        i_inc, i_inc2, j_inc, cnt_inc, cnt_after;
  logic                    more_j, more_i;
  logic                    pos_full, pos_bad;
  logic [CDS_P_W-1:0]      d2, d_full;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign eff_p = (CDS_P_W'(block_length_r) >= CDS_P_W'(MAX_BLOCK))
               ? CDS_P_W'(MAX_BLOCK) : CDS_P_W'(block_length_r);
  assign q_ok  = (in_query_distance != '0) &&
                 (CDS_P_W'(in_query_distance) <= CDS_P_W'(TABLE_DEPTH));

  assign i_inc   = i_r + 1'b1;
  assign i_inc2  = i_r + CNT_W'(2);
  assign j_inc   = j_r + 1'b1;
  assign cnt_inc = cnt_r + 1'b1;
  assign more_j  = (j_inc < cnt_r);
  assign more_i  = (i_inc2 < cnt_r);

  assign pos_full  = (cnt_r == CNT_W'(MAX_POSITIONS));
  assign pos_bad   = (CDS_P_W'(pos_r) >= p_r) || ((cnt_r != '0) && (pos_r <= last_pos_r));
  assign cnt_after = (!pos_full && !pos_bad) ? cnt_inc : cnt_r;

  // cyclic fold of the pair difference
  assign d2     = p_r - CDS_P_W'(d1_r);
  assign d_full = (CDS_P_W'(d1_r) >= d2) ? d2 : CDS_P_W'(d1_r);

  assign tbl_inc = (tbl_mult < CDS_MULT_CAP) ? (tbl_mult + 1'b1) : tbl_mult;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    epoch_nxt      = epoch_r;
    block_done_nxt = block_done_r;
    clr_addr_nxt   = clr_addr_r;
    from_load_nxt  = from_load_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_load       = 1'b0;
    store_we       = 1'b0;
    tbl_we         = 1'b0;
    st_raddr       = i_r[IDX_W-1:0];
    tbl_raddr      = q_addr_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_req_type == REQ_READ) begin
            state_nxt = S_RQ;
          end else if (block_done_r) begin
            // first load of a new block
            cnt_nxt        = '0;
            block_done_nxt = 1'b0;
            if (epoch_r == CDS_EPOCH_MAX) begin
              state_nxt     = S_CLEAR;
              clr_addr_nxt  = '0;
              from_load_nxt = 1'b1;
            end else begin
              epoch_nxt = epoch_r + 1'b1;
              state_nxt = S_CHECK;
            end
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CLEAR: begin
        tbl_we = 1'b1;
        if (clr_addr_r == TA_W'(TABLE_DEPTH - 1)) begin
          epoch_nxt     = CDS_EPOCH_FIRST;
          from_load_nxt = 1'b0;
          state_nxt     = from_load_r ? S_CHECK : S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      S_CHECK: begin
        store_we = !pos_full && !pos_bad;
        cnt_nxt  = cnt_after;
        if (final_r) begin
          block_done_nxt = 1'b1;
          i_nxt          = '0;
          state_nxt      = (cnt_after >= CNT_W'(2)) ? S_PA : S_OUT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_PA: begin
        st_raddr  = i_r[IDX_W-1:0];
        state_nxt = S_PB;
      end
      S_PB: begin
        j_nxt     = i_inc;
        st_raddr  = i_inc[IDX_W-1:0];
        state_nxt = S_PC;
      end
      S_PC: begin
        state_nxt = S_PD;
      end
      S_PD: begin
        tbl_raddr = TA_W'(d_full - 1'b1);
        state_nxt = S_PE;
      end
      S_PE: begin
        tbl_we = 1'b1;
        if (more_j) begin
          j_nxt     = j_inc;
          st_raddr  = j_inc[IDX_W-1:0];
          state_nxt = S_PC;
        end else if (more_i) begin
          i_nxt     = i_inc;
          st_raddr  = i_inc[IDX_W-1:0];
          state_nxt = S_PB;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_RQ: begin
        tbl_raddr = q_addr_r;
        state_nxt = S_RW;
      end
      S_RW: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign tbl_waddr = (state_r == S_CLEAR) ? clr_addr_r : tbl_addr_r;
  always_comb begin
    if (state_r == S_CLEAR) begin
      tbl_wentry.tag = CDS_EPOCH_NONE;
      tbl_wentry.cnt = '0;
    end else begin
      tbl_wentry.tag = epoch_r;
      tbl_wentry.cnt = tbl_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      cnt_r          <= '0;
      i_r            <= '0;
      j_r            <= '0;
      epoch_r        <= CDS_EPOCH_NONE;
      block_done_r   <= 1'b1;
      clr_addr_r     <= '0;
      from_load_r    <= 1'b0;
      out_valid_r    <= 1'b0;
      block_length_r <= CDS_BL_RESET;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      epoch_r      <= epoch_nxt;
      block_done_r <= block_done_nxt;
      clr_addr_r   <= clr_addr_nxt;
      from_load_r  <= from_load_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        block_length_r <= cfg_block_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      final_r  <= in_final_position;
      pos_r    <= in_position;
      q_ok_r   <= q_ok;
      q_addr_r <= TA_W'(in_query_distance - 1'b1);
      p_r      <= eff_p;
    end
    if (state_r == S_CHECK) begin
      mult_r <= '0;
      if (pos_full) begin
        status_r <= ST_FULL;
      end else if (pos_bad) begin
        status_r <= ST_BAD;
      end else begin
        status_r   <= ST_OK;
        last_pos_r <= pos_r;
      end
    end
    if (state_r == S_PB) begin
      pos_i_r <= store_q;
    end
    if (state_r == S_PC) begin
      d1_r <= store_q - pos_i_r;
    end
    if (state_r == S_PD) begin
      d_r        <= D_W'(d_full);
      tbl_addr_r <= TA_W'(d_full - 1'b1);
    end
    if (state_r == S_RW) begin
      status_r <= ST_OK;
      mult_r   <= q_ok_r ? tbl_mult : '0;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_mult_r   <= mult_r;
      out_held_r   <= CDS_HELD_W'(cnt_r);
    end
  end

  // position store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (store_we) begin
      pos_mem[cnt_r[IDX_W-1:0]] <= pos_r;
    end
    store_q <= pos_mem[st_raddr];
  end

  cds_spectrum #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TA_W        (TA_W)
  ) u_spectrum (
    .clk       (clk),
    .rd_addr   (tbl_raddr),
    .wr_en     (tbl_we),
    .wr_addr   (tbl_waddr),
    .wr_entry  (tbl_wentry),
    .cur_epoch (epoch_r),
    .rd_mult   (tbl_mult)
  );

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_multiplicity   = out_mult_r;
  assign out_positions_held = out_held_r;

  // store never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POSITIONS))
    else $error("position count above store depth");

  // a live block tag is never the tag that the sweep writes
  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_CLEAR |-> epoch_r != CDS_EPOCH_NONE)
    else $error("stale block tag in use");

  // held positions ascend, so every pair difference is positive
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PC |-> store_q > pos_i_r)
    else $error("pair walk saw positions out of order");

  // folded distance always lands inside the table
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PE |-> (d_r != '0) && (int'(d_r) <= TABLE_DEPTH))
    else $error("pair distance outside table");

  // a new result beat only comes from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result beat raised outside output state");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for cyclic_distance_spectrum; drives position loads, spectrum
// reads and block length writes, and predicts every result beat. depends on cds_pkg and the rtl

import cds_pkg::*;

typedef struct {
  status_t                status;
  logic [CDS_MULT_W-1:0]  mult;
  logic [CDS_HELD_W-1:0]  held;
} spectrum_reply_t;

class spectrum_scoreboard;
  logic [CDS_BL_W-1:0]   block_length;
  int unsigned           held_pos[$];
  bit                    block_done;
  logic [CDS_MULT_W-1:0] spectrum[1:CDS_MAX_BLOCK/2];
  spectrum_reply_t       awaited_replies[$];
  int unsigned           failures, n_loads, n_reads, n_blocks, n_full, n_bad, n_capped, n_cfg;

  function new();
    block_length = CDS_BL_RESET;
    block_done = 1'b1;
    foreach (spectrum[i]) spectrum[i] = '0;
  endfunction

  function void write_block_length(logic [CDS_BL_W-1:0] value);
    block_length = value;
    n_cfg++;
  endfunction

  function int unsigned pending();
    return awaited_replies.size();
  endfunction

  // works out the result of one accepted request and queues it
  function void note_request(logic req, logic [CDS_POS_W-1:0] pos, logic fin,
                             logic [CDS_POS_W-1:0] qd);
    spectrum_reply_t r;
    int unsigned     p, i, j, d1, d2, d;
    r.status = ST_OK;
    r.mult = '0;
    p = (block_length < CDS_MAX_BLOCK) ? block_length : CDS_MAX_BLOCK;
    if (req == REQ_LOAD) begin
      n_loads++;
      if (block_done) begin
        foreach (spectrum[k]) spectrum[k] = '0;
        held_pos.delete();
        block_done = 1'b0;
      end
      if (held_pos.size() >= CDS_MAX_POSITIONS) begin
        r.status = ST_FULL;
        n_full++;
      end else if (pos >= p || (held_pos.size() > 0 && pos <= held_pos[$])) begin
        r.status = ST_BAD;
        n_bad++;
      end else begin
        held_pos.push_back(pos);
      end
      // final mark ends the block even when this load was dropped
      if (fin) begin
        for (i = 0; i + 1 < held_pos.size(); i++) begin
          for (j = i + 1; j < held_pos.size(); j++) begin
            d1 = held_pos[j] - held_pos[i];
            d2 = p - d1;
            d = (d1 >= d2) ? d2 : d1;
            if (d >= 1 && d <= CDS_MAX_BLOCK / 2 && spectrum[d] < CDS_MULT_CAP)
              spectrum[d] = spectrum[d] + 1'b1;
          end
        end
        block_done = 1'b1;
        n_blocks++;
      end
    end else begin
      n_reads++;
      if (qd >= 1 && qd <= CDS_MAX_BLOCK / 2) r.mult = spectrum[qd];
      if (r.mult == CDS_MULT_CAP) n_capped++;
    end
    r.held = CDS_HELD_W'(held_pos.size());
    awaited_replies.push_back(r);
  endfunction

  function void report(string field, int unsigned exp_val, int unsigned act_val);
    failures++;
    if (failures <= 30)
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_val, act_val);
  endfunction

  function void check_reply(logic [1:0] st, logic [CDS_MULT_W-1:0] mult,
                            logic [CDS_HELD_W-1:0] held);
    spectrum_reply_t e;
    if (awaited_replies.size() == 0) begin
      report("unexpected beat, status", 0, st);
      return;
    end
    e = awaited_replies.pop_front();
    if (st !== e.status) report("status", e.status, st);
    if (mult !== e.mult) report("multiplicity", e.mult, mult);
    if (held !== e.held) report("positions_held", e.held, held);
  endfunction
endclass

module tb;
  localparam int RANDOM_ITEMS = 1430;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_req_type;
  logic [CDS_POS_W-1:0]  in_position;
  logic                  in_final_position;
  logic [CDS_POS_W-1:0]  in_query_distance;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_status;
  logic [CDS_MULT_W-1:0] out_multiplicity;
  logic [CDS_HELD_W-1:0] out_positions_held;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CDS_BL_W-1:0]   cfg_block_length;

  spectrum_scoreboard sb;
  int unsigned src_idle_pct, sink_idle_pct, items_offered, hold_left;
  bit          hold_request, hold_done;

  cyclic_distance_spectrum dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_position        (in_position),
    .in_final_position  (in_final_position),
    .in_query_distance  (in_query_distance),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_multiplicity   (out_multiplicity),
    .out_positions_held (out_positions_held),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_block_length   (cfg_block_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_block_length(cfg_block_length);
      if (in_valid && !in_stall)
        sb.note_request(in_req_type, in_position, in_final_position, in_query_distance);
      if (out_valid && !out_stall)
        sb.check_reply(out_status, out_multiplicity, out_positions_held);
    end
  end

  task automatic offer_request(input logic req, input logic [CDS_POS_W-1:0] pos,
                               input logic fin, input logic [CDS_POS_W-1:0] qd);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= req;
    in_position       <= pos;
    in_final_position <= fin;
    in_query_distance <= qd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_offered++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_block_length(input logic [CDS_BL_W-1:0] value);
    wait_drained();
    cfg_valid        <= 1'b1;
    cfg_block_length <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one block of ascending positions with some broken loads, then reads of its distances
  task automatic run_block(input int unsigned p);
    int unsigned w, lo, span, pos, k, r, a, b, d1, q;
    bit          dense;
    int unsigned kept[$];
    r = $urandom_range(99);
    if (r < 4) w = CDS_MAX_POSITIONS + $urandom_range(1, 3);
    else if (r < 10) w = $urandom_range(20, CDS_MAX_POSITIONS);
    else w = $urandom_range(1, 10);
    // dense blocks repeat distances so counts reach the cap
    dense = ($urandom_range(3) == 0);
    lo = 0;
    for (k = 0; k < w; k++) begin
      span = (lo < p) ? (p - lo) / (w - k) : 0;
      if (dense && span > 3) span = 3;
      pos = (span == 0) ? lo : lo + $urandom_range(0, span - 1);
      r = $urandom_range(99);
      if (r < 4) pos = $urandom_range(0, 32767);
      else if (r < 7 && kept.size() > 0) pos = kept[$];
      else if (r < 9) pos = p + $urandom_range(0, 3);
      pos = pos & 32'h7fff;
      if (pos < p && kept.size() < CDS_MAX_POSITIONS && (kept.size() == 0 || pos > kept[$]))
      begin
        kept.push_back(pos);
        lo = pos + 1;
      end
      if ($urandom_range(99) < 8)
        offer_request(REQ_READ, CDS_POS_W'($urandom_range(0, 32767)),
                      1'($urandom_range(0, 1)),
                      CDS_POS_W'($urandom_range(1, CDS_MAX_BLOCK / 2)));
      offer_request(REQ_LOAD, pos[CDS_POS_W-1:0], k == w - 1,
                    CDS_POS_W'($urandom_range(0, 32767)));
    end
    repeat ($urandom_range(1, 4)) begin
      if (kept.size() >= 2 && $urandom_range(3) != 0) begin
        a = $urandom_range(0, kept.size() - 2);
        b = $urandom_range(a + 1, kept.size() - 1);
        d1 = kept[b] - kept[a];
        q = (d1 < p - d1) ? d1 : p - d1;
      end else begin
        q = $urandom_range(0, 32767);
      end
      offer_request(REQ_READ, CDS_POS_W'($urandom_range(0, 32767)),
                    1'($urandom_range(0, 1)), q[CDS_POS_W-1:0]);
    end
  endtask

  initial begin
    int unsigned         k, ph, seg, eff;
    logic [CDS_BL_W-1:0] bl;
    bit                  held_off;
    sb = new();
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_req_type       <= REQ_LOAD;
    in_position       <= '0;
    in_final_position <= 1'b0;
    in_query_distance <= '0;
    cfg_valid         <= 1'b0;
    cfg_block_length  <= CDS_BL_RESET;
    src_idle_pct  = 28;
    sink_idle_pct = 83;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reads before any block, including distance zero and distance 32767, past the table
    offer_request(REQ_READ, 15'h7fff, 1'b1, 15'd1);
    offer_request(REQ_READ, 15'd0, 1'b0, 15'd0);
    offer_request(REQ_READ, 15'd0, 1'b0, 15'h7fff);
    // six adjacent positions at reset block length: distance one saturates
    for (k = 0; k < 6; k++) offer_request(REQ_LOAD, k[CDS_POS_W-1:0], k == 5, 15'h7fff);
    offer_request(REQ_READ, 15'd0, 1'b0, 15'd1);
    offer_request(REQ_READ, 15'd0, 1'b0, 15'd2);
    offer_request(REQ_READ, 15'd0, 1'b0, 15'd5);
    offer_request(REQ_READ, 15'd0, 1'b0, 15'd6);
    // largest block: repeated position, top position, half-block distance
    write_block_length(16'd32768);
    offer_request(REQ_LOAD, 15'd0, 1'b0, 15'd0);
    offer_request(REQ_LOAD, 15'd0, 1'b0, 15'd0);
    offer_request(REQ_LOAD, 15'd16384, 1'b0, 15'd0);
    offer_request(REQ_LOAD, 15'h7fff, 1'b1, 15'd0);
    offer_request(REQ_READ, 15'd0, 1'b0, 15'd16384);
    offer_request(REQ_READ, 15'd0, 1'b0, 15'd1);
    offer_request(REQ_READ, 15'd0, 1'b0, 15'd16383);
    offer_request(REQ_READ, 15'd0, 1'b0, 15'd16385);
    // smallest block: final mark on a dropped load with nothing held
    write_block_length(16'd3);
    offer_request(REQ_LOAD, 15'd3, 1'b1, 15'd0);
    offer_request(REQ_READ, 15'd0, 1'b0, 15'd1);

    seg = 0;
    held_off = 1'b0;
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 28;
          sink_idle_pct = 83;
        end
        1: begin
          src_idle_pct  = 83;
          sink_idle_pct = 28;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      while (items_offered < 23 + RANDOM_ITEMS * (ph + 1) / 3) begin
        case (seg % 8)
          0: bl = 16'd32768;
          1: bl = 16'd3;
          2: bl = CDS_BL_W'($urandom_range(3, 32768));
          3: bl = 16'hffff;
          4: bl = CDS_BL_W'($urandom_range(0, 1));
          5: bl = CDS_BL_RESET;
          6: bl = CDS_BL_W'($urandom_range(64, 130));
          default: bl = CDS_BL_W'($urandom_range(4, 200));
        endcase
        write_block_length(bl);
        eff = (bl < CDS_MAX_BLOCK) ? bl : CDS_MAX_BLOCK;
        // long receiver hold-off while loads keep coming, so the input backs up
        if (ph == 2 && !held_off) begin
          hold_request = 1'b1;
          held_off = 1'b1;
        end
        repeat ((eff < 8) ? 2 : 5) run_block(eff);
        seg++;
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    $display("covered %0d loads and %0d reads over %0d blocks, %0d block length writes",
             sb.n_loads, sb.n_reads, sb.n_blocks, sb.n_cfg);
    $display("dropped %0d loads on a full store and %0d on bad positions, %0d capped reads",
             sb.n_full, sb.n_bad, sb.n_capped);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
